[rtl/opg_pkg.sv]
// ----------------------------------------------------------------------------
// opg_pkg
// Shared types and constants of the orbit position generator: field widths,
// fixed-point formats of the sine/cosine series, register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package opg_pkg;

    // default parameter values
    localparam int PHASE_FRAC_BITS = 8;
    localparam int RADIUS_BITS     = 12;

    // beat field widths
    localparam int STEP_W   = 16;
    localparam int CENTER_W = 16;
    localparam int POS_W    = 17;

    // configuration port
    localparam int RADIUS_W   = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_RADIUS   = 1'b0;
    localparam t_cfg_idx REG_MIRROR_Y = 1'b1;

    // series arithmetic, values in Q30
    localparam int Q        = 30;
    localparam int X_W      = 31;   // angle in radians, below pi/2
    localparam int X2_W     = 32;   // angle squared, below 2.5
    localparam int TERM_W   = 31;   // series term magnitude
    localparam int NUM_W    = 32;   // term times angle squared, before divide
    localparam int SUM_W    = 33;   // signed partial sum
    localparam int MAG_W    = 32;   // magnitude of a selected sine/cosine
    localparam int NUM_TERMS = 8;   // cosine terms after the leading one
    localparam int SIN_TERMS = 7;   // sine terms after the leading one

    // pi/180 in Q32
    localparam int DEG_RAD_W = 27;
    localparam logic [DEG_RAD_W-1:0] DEG_TO_RAD_Q32 = 27'd74961321;

    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } t_quad;

    // values that ride along the series pipeline
    typedef struct packed {
        t_quad                       quad;
        logic [X2_W-1:0]             x2;
        logic signed [CENTER_W-1:0]  cx;
        logic signed [CENTER_W-1:0]  cy;
    } t_side;

    // one series lane (sine or cosine) at one step of one term
    typedef struct packed {
        logic [TERM_W-1:0]        term;
        logic [NUM_W-1:0]         num;
        logic [NUM_W-1:0]         quo;
        logic signed [SUM_W-1:0]  sum;
    } t_lane;

endpackage

`default_nettype wire

[rtl/opg_in_if.sv]
// ----------------------------------------------------------------------------
// opg_in_if
// Input channel: one beat per tick with the angle step and the orbit center.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface opg_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [opg_pkg::STEP_W-1:0]            angle_step;
    logic signed [opg_pkg::CENTER_W-1:0]   center_x;
    logic signed [opg_pkg::CENTER_W-1:0]   center_y;

    modport source (output valid, angle_step, center_x, center_y, input ready);
    modport sink   (input valid, angle_step, center_x, center_y, output ready);
endinterface

`default_nettype wire

[rtl/opg_out_if.sv]
// ----------------------------------------------------------------------------
// opg_out_if
// Output channel: one beat per tick with the orbit position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface opg_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [opg_pkg::POS_W-1:0]    pos_x;
    logic signed [opg_pkg::POS_W-1:0]    pos_y;

    modport source (output valid, pos_x, pos_y, input ready);
    modport sink   (input valid, pos_x, pos_y, output ready);
endinterface

`default_nettype wire

[rtl/orbit_position_generator.sv]
// ----------------------------------------------------------------------------
// orbit_position_generator
// Phase accumulator with quadrant folding and a pipelined sine/cosine power
// series; returns center plus radius times cosine and sine of the phase.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries one beat per tick: angle step (degrees, fractional bits
//   set by PHASE_FRAC_BITS) and the orbit center. o_result returns one beat
//   per input beat, in order: the position on the orbit.
//   The phase register adds the step when the beat is accepted; a sum above
//   360 degrees clears it to zero.
//   Radius and y mirror are written through i_cfg_we / i_cfg_idx / i_cfg_data;
//   the user must write them only while no beat is in flight, which the block does not enforce.
// Pipeline and throughput:
//   A result passes the capture register, then phase folding, angle
//   scaling and squaring, then the eight series terms (each a multiply, a
//   reciprocal multiply and a remainder correction), then the quadrant
//   selection, the radius scaling and the output register. One beat per
//   cycle while the output register is not stalled.
// Reset and stall:
//   Reset clears the phase, radius to zero and sets the y mirror. It empties
//   the pipeline. While the output register holds a beat that the receiver
//   does not take, the whole pipeline holds and i_item.ready is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module orbit_position_generator #(
    parameter int PHASE_FRAC_BITS = opg_pkg::PHASE_FRAC_BITS,
    parameter int RADIUS_BITS     = opg_pkg::RADIUS_BITS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    opg_in_if.sink                              i_item,
    opg_out_if.source                           o_result,
    input  wire                                 i_cfg_we,
    input  wire opg_pkg::t_cfg_idx              i_cfg_idx,
    input  wire [opg_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int FULL    = 360 << PHASE_FRAC_BITS;
    localparam int QUARTER = 90 << PHASE_FRAC_BITS;
    localparam int PH_W    = $clog2(FULL + 1);
    localparam int ACC_W   = $clog2(FULL + (1 << opg_pkg::STEP_W));
    localparam int T_W     = $clog2(QUARTER);
    localparam int XP_W    = T_W + opg_pkg::DEG_RAD_W;
    localparam int RAD_W   = (RADIUS_BITS < opg_pkg::RADIUS_W) ? RADIUS_BITS
                                                               : opg_pkg::RADIUS_W;
    localparam int P_W     = RAD_W + opg_pkg::MAG_W + 1;
    localparam int RND_W   = P_W - opg_pkg::Q;
    localparam int NT      = opg_pkg::NUM_TERMS;
    localparam int X2P_W   = 2 * opg_pkg::X_W;
    localparam int AP_W    = opg_pkg::TERM_W + opg_pkg::X2_W;
    localparam int BP_W    = 2 * opg_pkg::NUM_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [opg_pkg::RADIUS_W-1:0] r_radius;
    logic                         r_mirror_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= '0;
            r_mirror_y <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                opg_pkg::REG_RADIUS:   r_radius   <= i_cfg_data;
                opg_pkg::REG_MIRROR_Y: r_mirror_y <= i_cfg_data[0];
                default:               r_radius   <= r_radius;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // global advance: hold everything while the output beat waits
    // ------------------------------------------------------------------
    logic w_adv;
    logic w_accept;
    logic r_out_valid;

    assign w_adv        = !r_out_valid || o_result.ready;
    assign i_item.ready = w_adv;
    assign w_accept     = i_item.valid && w_adv;

    // ------------------------------------------------------------------
    // phase accumulator, cleared when the sum passes 360 degrees
    // ------------------------------------------------------------------
    logic [PH_W-1:0]  r_phase;
    logic [PH_W-1:0]  n_phase;
    logic [ACC_W-1:0] w_acc;

    assign w_acc   = ACC_W'(r_phase) + ACC_W'(i_item.angle_step);
    assign n_phase = (w_acc > ACC_W'(FULL)) ? '0 : w_acc[PH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
        end
    end

    // stage 0: capture the new phase and the center
    logic                                 r_s0_vld;
    logic [PH_W-1:0]                      r_s0_phase;
    logic signed [opg_pkg::CENTER_W-1:0]  r_s0_cx;
    logic signed [opg_pkg::CENTER_W-1:0]  r_s0_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_adv) begin
            r_s0_vld <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_phase <= n_phase;
            r_s0_cx    <= i_item.center_x;
            r_s0_cy    <= i_item.center_y;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: fold the phase into a quadrant and an angle below 90 degrees
    // ------------------------------------------------------------------
    logic                                 r_s1_vld;
    opg_pkg::t_quad                       r_s1_quad;
    logic [T_W-1:0]                       r_s1_t;
    logic signed [opg_pkg::CENTER_W-1:0]  r_s1_cx;
    logic signed [opg_pkg::CENTER_W-1:0]  r_s1_cy;
    opg_pkg::t_quad                       n_s1_quad;
    logic [PH_W-1:0]                      w_fold;

    always_comb begin
        // exactly 360 degrees falls into the first quadrant at zero
        priority if (r_s0_phase >= PH_W'(4 * QUARTER)) begin
            n_s1_quad = opg_pkg::QUAD_I;
            w_fold    = r_s0_phase - PH_W'(4 * QUARTER);
        end else if (r_s0_phase >= PH_W'(3 * QUARTER)) begin
            n_s1_quad = opg_pkg::QUAD_IV;
            w_fold    = r_s0_phase - PH_W'(3 * QUARTER);
        end else if (r_s0_phase >= PH_W'(2 * QUARTER)) begin
            n_s1_quad = opg_pkg::QUAD_III;
            w_fold    = r_s0_phase - PH_W'(2 * QUARTER);
        end else if (r_s0_phase >= PH_W'(QUARTER)) begin
            n_s1_quad = opg_pkg::QUAD_II;
            w_fold    = r_s0_phase - PH_W'(QUARTER);
        end else begin
            n_s1_quad = opg_pkg::QUAD_I;
            w_fold    = r_s0_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_quad <= n_s1_quad;
            r_s1_t    <= w_fold[T_W-1:0];
            r_s1_cx   <= r_s0_cx;
            r_s1_cy   <= r_s0_cy;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: degrees to radians in Q30, truncating
    // ------------------------------------------------------------------
    logic                                 r_s2_vld;
    opg_pkg::t_quad                       r_s2_quad;
    logic [opg_pkg::X_W-1:0]              r_s2_x;
    logic signed [opg_pkg::CENTER_W-1:0]  r_s2_cx;
    logic signed [opg_pkg::CENTER_W-1:0]  r_s2_cy;
    logic [XP_W-1:0]                      w_xprod;

    assign w_xprod = XP_W'(r_s1_t) * XP_W'(opg_pkg::DEG_TO_RAD_Q32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_adv) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_quad <= r_s1_quad;
            r_s2_x    <= w_xprod[PHASE_FRAC_BITS + 2 +: opg_pkg::X_W];
            r_s2_cx   <= r_s1_cx;
            r_s2_cy   <= r_s1_cy;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: square of the angle
    // ------------------------------------------------------------------
    logic                       r_s3_vld;
    logic [opg_pkg::X_W-1:0]    r_s3_x;
    opg_pkg::t_side             r_s3_side;
    logic [X2P_W-1:0]           w_x2prod;

    assign w_x2prod = X2P_W'(r_s2_x) * X2P_W'(r_s2_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_adv) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_x         <= r_s2_x;
            r_s3_side.quad <= r_s2_quad;
            r_s3_side.x2   <= w_x2prod[opg_pkg::Q +: opg_pkg::X2_W];
            r_s3_side.cx   <= r_s2_cx;
            r_s3_side.cy   <= r_s2_cy;
        end
    end

    // series seeds: sine starts at x, cosine at one
    opg_pkg::t_lane w_seed [2];

    always_comb begin
        w_seed[0].term = r_s3_x;
        w_seed[0].num  = '0;
        w_seed[0].quo  = '0;
        w_seed[0].sum  = $signed({2'b00, r_s3_x});
        w_seed[1].term = opg_pkg::TERM_W'(1) << opg_pkg::Q;
        w_seed[1].num  = '0;
        w_seed[1].quo  = '0;
        w_seed[1].sum  = opg_pkg::SUM_W'(1) << opg_pkg::Q;
    end

    // ------------------------------------------------------------------
    // series terms: lane 0 is sine, lane 1 is cosine; three stages a term
    // ------------------------------------------------------------------
    opg_pkg::t_lane r_lane_a [2][NT];
    opg_pkg::t_lane r_lane_b [2][NT];
    opg_pkg::t_lane r_lane_c [2][NT];
    opg_pkg::t_side r_side_a [NT];
    opg_pkg::t_side r_side_b [NT];
    opg_pkg::t_side r_side_c [NT];
    logic [NT-1:0]  r_vld_a;
    logic [NT-1:0]  r_vld_b;
    logic [NT-1:0]  r_vld_c;

    for (genvar k = 0; k < NT; k++) begin : g_term
        localparam int J = k + 1;

        opg_pkg::t_side w_side_in;
        logic           w_vld_in;

        if (k == 0) begin : g_first
            assign w_side_in = r_s3_side;
            assign w_vld_in  = r_s3_vld;
        end else begin : g_next
            assign w_side_in = r_side_c[k-1];
            assign w_vld_in  = r_vld_c[k-1];
        end

        // carry side values and valid bits through the three stages
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld_a[k] <= 1'b0;
                r_vld_b[k] <= 1'b0;
                r_vld_c[k] <= 1'b0;
            end else if (w_adv) begin
                r_vld_a[k] <= w_vld_in;
                r_vld_b[k] <= r_vld_a[k];
                r_vld_c[k] <= r_vld_b[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_side_a[k] <= w_side_in;
                r_side_b[k] <= r_side_a[k];
                r_side_c[k] <= r_side_b[k];
            end
        end

        for (genvar L = 0; L < 2; L++) begin : g_lane
            opg_pkg::t_lane w_in;
            opg_pkg::t_lane n_a;
            opg_pkg::t_lane n_b;
            opg_pkg::t_lane n_c;

            if (k == 0) begin : g_seed
                assign w_in = w_seed[L];
            end else begin : g_chain
                assign w_in = r_lane_c[L][k-1];
            end

            if ((L == 1) || (J <= opg_pkg::SIN_TERMS)) begin : g_work
                localparam int DIV_INT = (L == 0) ? (2 * J) * (2 * J + 1)
                                                  : (2 * J - 1) * (2 * J);
                localparam logic [BP_W-1:0] RECIP_FULL =
                    (BP_W'(1) << opg_pkg::NUM_W) / BP_W'(DIV_INT);
                localparam logic [opg_pkg::NUM_W-1:0] DIV   = opg_pkg::NUM_W'(DIV_INT);
                localparam logic [opg_pkg::NUM_W-1:0] RECIP =
                    RECIP_FULL[opg_pkg::NUM_W-1:0];

                logic [AP_W-1:0]           w_prod_a;
                logic [BP_W-1:0]           w_prod_b;
                logic [opg_pkg::NUM_W-1:0] w_qd;
                logic [opg_pkg::NUM_W-1:0] w_rem;
                logic [opg_pkg::NUM_W-1:0] w_quo;
                logic signed [opg_pkg::SUM_W-1:0] w_term_s;

                // multiply the previous term by the angle squared
                assign w_prod_a = AP_W'(w_in.term) * AP_W'(w_side_in.x2);

                always_comb begin
                    n_a     = w_in;
                    n_a.num = w_prod_a[opg_pkg::Q +: opg_pkg::NUM_W];
                end

                // estimate the quotient by the reciprocal, low by at most one
                assign w_prod_b = BP_W'(r_lane_a[L][k].num) * BP_W'(RECIP);

                always_comb begin
                    n_b     = r_lane_a[L][k];
                    n_b.quo = w_prod_b[opg_pkg::NUM_W +: opg_pkg::NUM_W];
                end

                // correct the quotient by the remainder and fold into the sum
                assign w_qd     = opg_pkg::NUM_W'(r_lane_b[L][k].quo * DIV);
                assign w_rem    = r_lane_b[L][k].num - w_qd;
                assign w_quo    = (w_rem >= DIV) ? r_lane_b[L][k].quo + 1'b1
                                                 : r_lane_b[L][k].quo;
                assign w_term_s = $signed({2'b00, w_quo[opg_pkg::TERM_W-1:0]});

                always_comb begin
                    n_c      = r_lane_b[L][k];
                    n_c.term = w_quo[opg_pkg::TERM_W-1:0];
                    if ((J % 2) == 1) begin
                        n_c.sum = r_lane_b[L][k].sum - w_term_s;
                    end else begin
                        n_c.sum = r_lane_b[L][k].sum + w_term_s;
                    end
                end
            end else begin : g_pass
                // sine has one term fewer: pass the lane through
                assign n_a = w_in;
                assign n_b = r_lane_a[L][k];
                assign n_c = r_lane_b[L][k];
            end

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_lane_a[L][k] <= n_a;
                    r_lane_b[L][k] <= n_b;
                    r_lane_c[L][k] <= n_c;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage F1: pick signed cosine and sine for the quadrant, split sign
    // ------------------------------------------------------------------
    logic signed [opg_pkg::SUM_W-1:0]     w_sin;
    logic signed [opg_pkg::SUM_W-1:0]     w_cos;
    logic signed [opg_pkg::SUM_W-1:0]     w_cv;
    logic signed [opg_pkg::SUM_W-1:0]     w_sv;
    logic signed [opg_pkg::SUM_W-1:0]     w_cv_abs;
    logic signed [opg_pkg::SUM_W-1:0]     w_sv_abs;
    logic                                 r_f1_vld;
    logic [opg_pkg::MAG_W-1:0]            r_f1_mag_x;
    logic [opg_pkg::MAG_W-1:0]            r_f1_mag_y;
    logic                                 r_f1_neg_x;
    logic                                 r_f1_neg_y;
    logic signed [opg_pkg::CENTER_W-1:0]  r_f1_cx;
    logic signed [opg_pkg::CENTER_W-1:0]  r_f1_cy;

    assign w_sin = r_lane_c[0][NT-1].sum;
    assign w_cos = r_lane_c[1][NT-1].sum;

    always_comb begin
        unique case (r_side_c[NT-1].quad)
            opg_pkg::QUAD_I:   begin w_cv = w_cos;  w_sv = w_sin;  end
            opg_pkg::QUAD_II:  begin w_cv = -w_sin; w_sv = w_cos;  end
            opg_pkg::QUAD_III: begin w_cv = -w_cos; w_sv = -w_sin; end
            opg_pkg::QUAD_IV:  begin w_cv = w_sin;  w_sv = -w_cos; end
            default:           begin w_cv = w_cos;  w_sv = w_sin;  end
        endcase
    end

    assign w_cv_abs = w_cv[opg_pkg::SUM_W-1] ? -w_cv : w_cv;
    assign w_sv_abs = w_sv[opg_pkg::SUM_W-1] ? -w_sv : w_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
        end else if (w_adv) begin
            r_f1_vld <= r_vld_c[NT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f1_mag_x <= w_cv_abs[opg_pkg::MAG_W-1:0];
            r_f1_mag_y <= w_sv_abs[opg_pkg::MAG_W-1:0];
            r_f1_neg_x <= w_cv[opg_pkg::SUM_W-1];
            r_f1_neg_y <= w_sv[opg_pkg::SUM_W-1];
            r_f1_cx    <= r_side_c[NT-1].cx;
            r_f1_cy    <= r_side_c[NT-1].cy;
        end
    end

    // ------------------------------------------------------------------
    // stage F2: scale by the radius and round the magnitude
    // ------------------------------------------------------------------
    logic [P_W-1:0]                       w_px;
    logic [P_W-1:0]                       w_py;
    logic                                 r_f2_vld;
    logic [RND_W-1:0]                     r_f2_px;
    logic [RND_W-1:0]                     r_f2_py;
    logic                                 r_f2_neg_x;
    logic                                 r_f2_neg_y;
    logic signed [opg_pkg::CENTER_W-1:0]  r_f2_cx;
    logic signed [opg_pkg::CENTER_W-1:0]  r_f2_cy;

    assign w_px = P_W'(r_radius[RAD_W-1:0]) * P_W'(r_f1_mag_x)
                + (P_W'(1) << (opg_pkg::Q - 1));
    assign w_py = P_W'(r_radius[RAD_W-1:0]) * P_W'(r_f1_mag_y)
                + (P_W'(1) << (opg_pkg::Q - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_vld <= 1'b0;
        end else if (w_adv) begin
            r_f2_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f2_px    <= w_px[P_W-1:opg_pkg::Q];
            r_f2_py    <= w_py[P_W-1:opg_pkg::Q];
            r_f2_neg_x <= r_f1_neg_x;
            r_f2_neg_y <= r_f1_neg_y;
            r_f2_cx    <= r_f1_cx;
            r_f2_cy    <= r_f1_cy;
        end
    end

    // ------------------------------------------------------------------
    // output register: apply signs and mirror, add the center
    // ------------------------------------------------------------------
    logic signed [opg_pkg::POS_W-1:0] w_off_x;
    logic signed [opg_pkg::POS_W-1:0] w_off_y;
    logic signed [opg_pkg::POS_W-1:0] r_pos_x;
    logic signed [opg_pkg::POS_W-1:0] r_pos_y;

    assign w_off_x = r_f2_neg_x ? -$signed(opg_pkg::POS_W'(r_f2_px))
                                :  $signed(opg_pkg::POS_W'(r_f2_px));
    assign w_off_y = (r_f2_neg_y ^ r_mirror_y) ? -$signed(opg_pkg::POS_W'(r_f2_py))
                                               :  $signed(opg_pkg::POS_W'(r_f2_py));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_f2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pos_x <= opg_pkg::POS_W'(r_f2_cx) + w_off_x;
            r_pos_y <= opg_pkg::POS_W'(r_f2_cy) + w_off_y;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.pos_x = r_pos_x;
    assign o_result.pos_y = r_pos_y;

endmodule

`default_nettype wire

[rtl/opg_checker.sv]
// ----------------------------------------------------------------------------
// opg_checker
// Port-level checks of the orbit position generator: reset, output stall,
// input backpressure and beats in flight. Bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module opg_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    input  wire                                i_in_ready,
    input  wire                                i_out_valid,
    input  wire                                i_out_ready,
    input  wire signed [opg_pkg::POS_W-1:0]    i_pos_x,
    input  wire signed [opg_pkg::POS_W-1:0]    i_pos_y
);

    localparam int CNT_W = 6;

    // count beats accepted and not yet delivered
    logic [CNT_W-1:0] r_inflight;
    logic [CNT_W-1:0] n_inflight;

    always_comb begin
        n_inflight = r_inflight;
        if (i_in_valid && i_in_ready) begin
            n_inflight = n_inflight + 1'b1;
        end
        if (i_out_valid && i_out_ready) begin
            n_inflight = n_inflight - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output beat valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_pos_x) && $stable(i_pos_y))
        else $error("stalled output beat changed");

    // input is held back only by a waiting result
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow the output stall");

    // no result without an accepted beat behind it
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_inflight != '0)
        else $error("output beat with no input beat in flight");

endmodule

bind orbit_position_generator opg_checker u_opg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_pos_x     (o_result.pos_x),
    .i_pos_y     (o_result.pos_y)
);

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for orbit_position_generator. A bit-exact predictor of
// the phase accumulator, quadrant folding, power series and rounding yields
// the expected position for every accepted step beat. The result channel is
// checked in order against those expectations. Directed corners come first,
// then random orbits over several radius and mirror settings, with random
// gaps on the step channel and random stalls on the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int     CLK_PERIOD   = 12;
    localparam int     RESET_CYCLES = 5;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     MAX_IDLE     = 18;
    localparam int     MAX_REPORTS  = 10;
    localparam int     PIPE_LATENCY = 30;
    localparam int     ORBIT_RUNS   = 9;
    localparam int     RUN_BEATS    = 200;
    localparam longint FULL_TURN    = longint'(360) << opg_pkg::PHASE_FRAC_BITS;
    localparam longint QUARTER_TURN = longint'(90) << opg_pkg::PHASE_FRAC_BITS;
    localparam longint ONE_Q30      = longint'(1) << opg_pkg::Q;
    localparam longint HALF_Q30     = longint'(1) << (opg_pkg::Q - 1);

    typedef struct {
        logic [opg_pkg::POS_W-1:0] pos_x;
        logic [opg_pkg::POS_W-1:0] pos_y;
    } t_position;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           cfg_we;
    opg_pkg::t_cfg_idx              cfg_idx;
    logic [opg_pkg::CFG_DATA_W-1:0] cfg_data;

    opg_in_if  item_if ();
    opg_out_if result_if ();

    // predictor state and configuration copy
    longint    orbit_phase;
    longint    orbit_radius;
    bit        orbit_mirror_y;
    t_position expected_positions[$];

    int        mismatches  = 0;
    int        cycle_count = 0;
    bit        step_gaps   = 1'b0;
    bit        result_stalls = 1'b0;

    orbit_position_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_result   (result_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // sine and cosine of an angle in Q30 radians below pi/2, both in Q30
    function automatic void series_sin_cos(input longint ang, output longint s,
                                           output longint c);
        longint x2;
        longint term;
        longint acc;
        x2   = (ang * ang) >>> opg_pkg::Q;
        term = ang;
        acc  = ang;
        for (int k = 1; k <= opg_pkg::SIN_TERMS; k++) begin
            term = ((term * x2) >>> opg_pkg::Q) / longint'((2 * k) * (2 * k + 1));
            acc  = (k % 2 == 1) ? acc - term : acc + term;
        end
        s    = acc;
        term = ONE_Q30;
        acc  = ONE_Q30;
        for (int k = 1; k <= opg_pkg::NUM_TERMS; k++) begin
            term = ((term * x2) >>> opg_pkg::Q) / longint'((2 * k - 1) * (2 * k));
            acc  = (k % 2 == 1) ? acc - term : acc + term;
        end
        c = acc;
    endfunction

    // radius times a Q30 value, rounded half away from zero
    function automatic longint round_scaled(input longint r, input longint v);
        longint mag;
        longint prod;
        mag  = (v < 0) ? -v : v;
        prod = (r * mag + HALF_Q30) >>> opg_pkg::Q;
        return (v < 0) ? -prod : prod;
    endfunction

    // advance the phase by one step and return the position it gives
    function automatic t_position advance_orbit(
        input logic [opg_pkg::STEP_W-1:0]          step,
        input logic signed [opg_pkg::CENTER_W-1:0] cx,
        input logic signed [opg_pkg::CENTER_W-1:0] cy);
        longint         quarters;
        longint         frac_angle;
        longint         ang;
        longint         s, c, cv, sv;
        longint         off_y;
        longint         px, py;
        opg_pkg::t_quad quad;
        t_position      pos;
        orbit_phase = orbit_phase + longint'({1'b0, step});
        // past a full turn the phase restarts from zero
        if (orbit_phase > FULL_TURN) begin
            orbit_phase = 0;
        end
        quarters   = orbit_phase / QUARTER_TURN;
        frac_angle = orbit_phase - quarters * QUARTER_TURN;
        quad       = opg_pkg::t_quad'(quarters[1:0]);
        ang = (frac_angle * longint'(opg_pkg::DEG_TO_RAD_Q32))
              >>> (opg_pkg::PHASE_FRAC_BITS + 2);
        series_sin_cos(ang, s, c);
        case (quad)
            opg_pkg::QUAD_I: begin
                cv = c;
                sv = s;
            end
            opg_pkg::QUAD_II: begin
                cv = -s;
                sv = c;
            end
            opg_pkg::QUAD_III: begin
                cv = -c;
                sv = -s;
            end
            default: begin
                cv = s;
                sv = -c;
            end
        endcase
        off_y = round_scaled(orbit_radius, sv);
        if (orbit_mirror_y) begin
            off_y = -off_y;
        end
        px = longint'(cx) + round_scaled(orbit_radius, cv);
        py = longint'(cy) + off_y;
        pos.pos_x = px[opg_pkg::POS_W-1:0];
        pos.pos_y = py[opg_pkg::POS_W-1:0];
        return pos;
    endfunction

    // compare one result beat with the oldest expected position
    task automatic check_position();
        t_position want;
        if (expected_positions.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("unexpected result beat: x=%0d y=%0d",
                         result_if.pos_x, result_if.pos_y);
            end
            return;
        end
        want = expected_positions.pop_front();
        if (want.pos_x !== result_if.pos_x || want.pos_y !== result_if.pos_y) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("position mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                         $signed(want.pos_x), $signed(want.pos_y),
                         result_if.pos_x, result_if.pos_y);
            end
        end
    endtask

    // take result beats; with result stalls on, hold ready low for a random gap after each one
    initial begin
        int hold;
        hold = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
                check_position();
                hold = result_stalls ? $urandom_range(0, MAX_IDLE) : 0;
            end else if (hold > 0) begin
                hold--;
            end
            result_if.ready <= (hold == 0);
        end
    end

    // fail the run if it is still going at the cycle limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // send one step beat, after a random gap when step gaps are on, and record its expected position
    task automatic send_step(input logic [opg_pkg::STEP_W-1:0]          step,
                             input logic signed [opg_pkg::CENTER_W-1:0] cx,
                             input logic signed [opg_pkg::CENTER_W-1:0] cy);
        int gap;
        gap = step_gaps ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid      <= 1'b1;
        item_if.angle_step <= step;
        item_if.center_x   <= cx;
        item_if.center_y   <= cy;
        do begin
            @(posedge i_clk);
        end while (item_if.ready !== 1'b1);
        expected_positions.push_back(advance_orbit(step, cx, cy));
    endtask

    // drop valid and wait until every expected position has come back
    task automatic wait_drained();
        item_if.valid <= 1'b0;
        while (expected_positions.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2) @(posedge i_clk);
    endtask

    // write radius, then the y mirror, on consecutive cycles
    task automatic configure(input int radius, input bit mirror);
        cfg_we   <= 1'b1;
        cfg_idx  <= opg_pkg::REG_RADIUS;
        cfg_data <= opg_pkg::CFG_DATA_W'(radius);
        @(posedge i_clk);
        cfg_idx  <= opg_pkg::REG_MIRROR_Y;
        cfg_data <= opg_pkg::CFG_DATA_W'(mirror);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        orbit_radius   = longint'(opg_pkg::RADIUS_W'(radius))
                       & ((longint'(1) << opg_pkg::RADIUS_BITS) - 1);
        orbit_mirror_y = mirror;
    endtask

    // after reset the radius is zero, so the position is the center itself
    task automatic test_reset_state();
        step_gaps     = 1'b0;
        result_stalls = 1'b0;
        send_step('0, 16'sd100, -16'sd100);
        send_step('0, 16'sh7FFF, 16'sh8000);
        wait_drained();
    endtask

    // quadrant edges, exact full turn, overflow past a full turn, extremes
    task automatic test_directed_corners();
        step_gaps     = 1'b1;
        result_stalls = 1'b1;
        configure(4095, 1'b0);
        send_step(16'd0, 16'sh7FFF, 16'sh7FFF);
        send_step(16'd0, 16'sh8000, 16'sh8000);
        send_step(16'd23040, 16'sh7FFF, 16'sh8000);
        send_step(16'd23040, 16'sh8000, 16'sh7FFF);
        send_step(16'd23040, 16'sd0, 16'sd0);
        send_step(16'd23040, 16'sd0, 16'sd0);
        send_step(16'd1, 16'sd0, 16'sd0);
        send_step(16'hFFFF, 16'sh7FFF, 16'sh7FFF);
        send_step(16'hFFFF, -16'sd1, 16'sd1);
        send_step(16'd32, 16'sd0, 16'sd0);
        send_step(16'd11520, 16'sd0, 16'sd0);
        wait_drained();
        configure(4095, 1'b1);
        send_step(16'd11520, 16'sd1000, -16'sd1000);
        send_step(16'd23040, 16'sh8000, 16'sh8000);
        send_step(16'd23040, 16'sh7FFF, 16'sh7FFF);
        send_step(16'd46080, 16'sd0, 16'sd0);
        send_step(16'd5555, 16'sh5555, 16'shAAAA);
        wait_drained();
    endtask

    // one random beat: small, arbitrary, eighth-quadrant multiples or full-turn steps
    task automatic send_random_step();
        int                                   kind;
        longint                               to_turn;
        logic [opg_pkg::STEP_W-1:0]           step;
        logic signed [opg_pkg::CENTER_W-1:0]  cx;
        logic signed [opg_pkg::CENTER_W-1:0]  cy;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            step = opg_pkg::STEP_W'($urandom_range(0, 1023));
        end else if (kind < 70) begin
            step = opg_pkg::STEP_W'($urandom_range(0, 65535));
        end else if (kind < 85) begin
            step = opg_pkg::STEP_W'($urandom_range(0, 22) * 2880);
        end else begin
            // land on the full turn exactly or just past it
            to_turn = FULL_TURN - orbit_phase;
            if (to_turn <= 65534) begin
                step = opg_pkg::STEP_W'(to_turn + longint'($urandom_range(0, 1)));
            end else begin
                step = '1;
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            cx = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end else begin
            cx = opg_pkg::CENTER_W'($urandom());
        end
        if ($urandom_range(0, 9) == 0) begin
            cy = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end else begin
            cy = opg_pkg::CENTER_W'($urandom());
        end
        send_step(step, cx, cy);
    endtask

    // random orbits over a sweep of radius, mirror and idling modes
    task automatic test_random_orbits();
        int radius;
        for (int n = 0; n < ORBIT_RUNS; n++) begin
            if (n == 0) begin
                radius = 0;
            end else if (n == 1) begin
                radius = 4095;
            end else if (n == 2) begin
                radius = 1;
            end else begin
                radius = $urandom_range(0, 4095);
            end
            configure(radius, 1'(n % 2));
            step_gaps     = (n % 4 == 0) || (n % 4 == 1);
            result_stalls = (n % 4 == 0) || (n % 4 == 2);
            repeat (RUN_BEATS) send_random_step();
            wait_drained();
        end
    endtask

    // reset, run the tests in turn, then report
    initial begin
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= opg_pkg::REG_RADIUS;
        cfg_data           <= '0;
        item_if.valid      <= 1'b0;
        item_if.angle_step <= '0;
        item_if.center_x   <= '0;
        item_if.center_y   <= '0;
        orbit_phase    = 0;
        orbit_radius   = 0;
        orbit_mirror_y = 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_directed_corners();
        test_random_orbits();
        wait_drained();
        repeat (PIPE_LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
